/* sv/tlos_pkg.sv */
// ---------------------------------------------------------------------------
// tlos_pkg
// shared constants and defaults for the terrain line-of-sight test block
// ---------------------------------------------------------------------------
package tlos_pkg;

  localparam int MAP_SIDE_DEF    = 256;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam logic [12:0] RADIUS_RESET = 13'd1600;

  // operation codes carried in the input tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

/* sv/tlos_ram.sv */
// ---------------------------------------------------------------------------
// tlos_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module tlos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tlos_mul.sv */
// ---------------------------------------------------------------------------
// tlos_mul
// shared signed multiplier with registered product
// ---------------------------------------------------------------------------
module tlos_mul #(
  parameter int AW = 19,
  parameter int BW = 15
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

/* sv/terrain_line_of_sight_test.sv */
// ---------------------------------------------------------------------------
// terrain_line_of_sight_test
// height map store plus a sequencer that walks a ray over the map around
// one shared multiplier
// ---------------------------------------------------------------------------
// map write: a write does not leave the idle state, so in_tready stays high
// query: setup (squares, radius check, a 9-step square root on the shared
//   multiplier), then a ray walk of up to t samples, t = ceil(sqrt(2*dist^2)) up to 510
// throughput: one query at a time, bounded by the walk issuing one map read a cycle
// reset: rst_n synchronous active low, radius goes to 1600, map contents undefined
module terrain_line_of_sight_test #(
  parameter int MAP_SIDE    = tlos_pkg::MAP_SIDE_DEF,
  parameter int HEIGHT_BITS = tlos_pkg::HEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg word: radius_sixteenths
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_x, cell_y, terrain_height, station_x, station_y, antenna_height, pad
  input  logic [63:0] in_tdata,
  // operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // visible, beyond_radius, pad
  output logic [7:0]  out_tdata
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int HB    = HEIGHT_BITS;
  localparam int HSW   = ((HB > 13) ? HB : 13) + 1;   // station top height
  localparam int SLW   = HSW + 1;                       // slope, also mult a width
  localparam int MBW   = 15;
  localparam int PW    = SLW + MBW;
  localparam int TW    = 10;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQX    = 4'd1;
  localparam logic [3:0] S_SQY    = 4'd2;
  localparam logic [3:0] S_RAD    = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_RD_S   = 4'd5;
  localparam logic [3:0] S_RD_T   = 4'd6;
  localparam logic [3:0] S_RD_W   = 4'd7;
  localparam logic [3:0] S_SQRT_M = 4'd8;
  localparam logic [3:0] S_SQRT_C = 4'd9;
  localparam logic [3:0] S_CEIL_M = 4'd10;
  localparam logic [3:0] S_CEIL_C = 4'd11;
  localparam logic [3:0] S_INIT_M = 4'd12;
  localparam logic [3:0] S_INIT_C = 4'd13;
  localparam logic [3:0] S_WALK   = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
    cell_addr = AW'(x) * AW'(MAP_SIDE) + AW'(y);
  endfunction

  function automatic logic on_map(input logic [7:0] x);
    on_map = 32'(x) < MAP_SIDE;
  endfunction

  // input word fields
  logic [7:0]  in_cx, in_cy, in_sx, in_sy;
  logic [15:0] in_th;
  logic [11:0] in_ant;
  assign in_cx  = in_tdata[7:0];
  assign in_cy  = in_tdata[15:8];
  assign in_th  = in_tdata[31:16];
  assign in_sx  = in_tdata[39:32];
  assign in_sy  = in_tdata[47:40];
  assign in_ant = in_tdata[59:48];

  logic [3:0]  state_r;
  logic [12:0] radius_r;
  logic [7:0]  tx_r, ty_r, sx_r, sy_r, px_r, py_r;
  logic [11:0] ant_r;
  logic [16:0] dist_r;
  logic [17:0] v_r;
  logic [TW-1:0] root_r, t_r, i_r;
  logic [3:0]  bit_r;
  logic signed [HSW-1:0] hs_r;
  logic signed [HB-1:0]  ht_r;
  logic signed [SLW-1:0] slope_r;
  logic signed [PW-1:0]  ray_r, s1_ray_r, s2_ray_r;
  logic signed [11:0]    remx_r, remy_r;
  logic        s1_v_r, s2_v_r, hit_r;
  logic [1:0]  res_r;        // beyond, visible
  logic        out_valid_r;
  logic [1:0]  out_data_r;

  // signed offsets from station to target
  logic signed [8:0] dx, dy;
  assign dx = $signed({1'b0, tx_r}) - $signed({1'b0, sx_r});
  assign dy = $signed({1'b0, ty_r}) - $signed({1'b0, sy_r});

  // map store signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic signed [HB-1:0] ram_wdata, ram_rdata;
  logic                 in_acc;

  // shared multiplier
  logic signed [SLW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod;
  logic [TW-1:0]         trial;

  assign trial = root_r | (TW'(1) << bit_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX: begin
        mul_a = SLW'(dx);
        mul_b = MBW'(dx);
      end
      S_SQY: begin
        mul_a = SLW'(dy);
        mul_b = MBW'(dy);
      end
      S_RAD: begin
        mul_a = SLW'($signed({1'b0, radius_r}));
        mul_b = MBW'($signed({1'b0, radius_r}));
      end
      S_SQRT_M: begin
        mul_a = SLW'($signed({1'b0, trial}));
        mul_b = MBW'($signed({1'b0, trial}));
      end
      S_CEIL_M: begin
        mul_a = SLW'($signed({1'b0, root_r}));
        mul_b = MBW'($signed({1'b0, root_r}));
      end
      S_INIT_M: begin
        mul_a = SLW'(hs_r);
        mul_b = MBW'($signed({1'b0, t_r}));
      end
      S_WALK: begin
        mul_a = SLW'(ram_rdata);
        mul_b = MBW'($signed({1'b0, t_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tlos_mul #(.AW(SLW), .BW(MBW)) u_mul (
    .clk   (clk),
    .a     (mul_a),
    .b     (mul_b),
    .prod_r(prod)
  );

  // map store
  assign in_acc    = in_tvalid && in_tready;
  assign ram_we    = in_acc && (in_tuser == tlos_pkg::OP_WRITE) && on_map(in_cx) && on_map(in_cy);
  assign ram_waddr = cell_addr(in_cx, in_cy);
  assign ram_wdata = HB'($signed(in_th));

  always_comb begin
    case (state_r)
      S_RD_S:  ram_raddr = cell_addr(sx_r, sy_r);
      S_RD_T:  ram_raddr = cell_addr(tx_r, ty_r);
      default: ram_raddr = cell_addr(px_r, py_r);
    endcase
  end

  tlos_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // walk step: issue one sample, update incremental floor of the path
  logic issue;
  logic signed [11:0] remx_a, remy_a, t_s;
  assign issue  = (i_r != t_r) && !hit_r;
  assign t_s    = 12'($signed({1'b0, t_r}));
  assign remx_a = remx_r + 12'(dx);
  assign remy_a = remy_r + 12'(dy);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= tlos_pkg::RADIUS_RESET;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radius_r <= cfg_data;
      end
      // the result register is reloaded in the done state
      if (out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == tlos_pkg::OP_QUERY)) begin
            tx_r  <= in_cx;
            ty_r  <= in_cy;
            sx_r  <= in_sx;
            sy_r  <= in_sy;
            ant_r <= in_ant;
            if (on_map(in_cx) && on_map(in_cy) && on_map(in_sx) && on_map(in_sy)) begin
              state_r <= S_SQX;
            end else begin
              res_r   <= 2'b00;
              state_r <= S_DONE;
            end
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          dist_r  <= 17'(prod);
          state_r <= S_RAD;
        end
        S_RAD: begin
          dist_r  <= dist_r + 17'(prod);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if ({dist_r, 8'd0} > 25'(prod[25:0]) || prod[25]) begin
            if ({1'b0, dist_r, 8'd0} > prod[25:0]) begin
              res_r   <= 2'b10;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD_S;
            end
          end else begin
            state_r <= S_RD_S;
          end
          v_r    <= {dist_r, 1'b0};
          root_r <= '0;
          bit_r  <= 4'd8;
        end
        S_RD_S: state_r <= S_RD_T;
        S_RD_T: begin
          hs_r    <= HSW'(ram_rdata) + HSW'($signed({1'b0, ant_r}));
          state_r <= S_RD_W;
        end
        S_RD_W: begin
          ht_r    <= ram_rdata;
          state_r <= S_SQRT_M;
        end
        S_SQRT_M: state_r <= S_SQRT_C;
        S_SQRT_C: begin
          if (prod[19:0] <= {2'b00, v_r}) begin
            root_r <= trial;
          end
          if (bit_r == 4'd0) begin
            state_r <= S_CEIL_M;
          end else begin
            bit_r   <= bit_r - 4'd1;
            state_r <= S_SQRT_M;
          end
        end
        S_CEIL_M: state_r <= S_CEIL_C;
        S_CEIL_C: begin
          if (v_r == 18'd0) begin
            res_r   <= 2'b01;
            state_r <= S_DONE;
          end else begin
            t_r     <= (prod[19:0] < {2'b00, v_r}) ? root_r + TW'(1) : root_r;
            state_r <= S_INIT_M;
          end
        end
        S_INIT_M: begin
          slope_r <= SLW'(ht_r) - SLW'(hs_r);
          state_r <= S_INIT_C;
        end
        S_INIT_C: begin
          ray_r   <= prod;
          px_r    <= sx_r;
          py_r    <= sy_r;
          remx_r  <= '0;
          remy_r  <= '0;
          i_r     <= '0;
          hit_r   <= 1'b0;
          s1_v_r  <= 1'b0;
          s2_v_r  <= 1'b0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          // stage 1: sample issued, map read in flight
          s1_v_r   <= issue;
          s1_ray_r <= ray_r;
          if (issue) begin
            ray_r <= ray_r + PW'(slope_r);
            i_r   <= i_r + TW'(1);
            if (remx_a >= t_s) begin
              remx_r <= remx_a - t_s;
              px_r   <= px_r + 8'd1;
            end else if (remx_a < 0) begin
              remx_r <= remx_a + t_s;
              px_r   <= px_r - 8'd1;
            end else begin
              remx_r <= remx_a;
            end
            if (remy_a >= t_s) begin
              remy_r <= remy_a - t_s;
              py_r   <= py_r + 8'd1;
            end else if (remy_a < 0) begin
              remy_r <= remy_a + t_s;
              py_r   <= py_r - 8'd1;
            end else begin
              remy_r <= remy_a;
            end
          end
          // stage 2: ground times t on the multiplier
          s2_v_r   <= s1_v_r && !hit_r;
          s2_ray_r <= s1_ray_r;
          // stage 3: terrain above the ray blocks the view
          if (s2_v_r && (s2_ray_r < prod)) begin
            hit_r <= 1'b1;
          end
          if (hit_r || (!issue && !s1_v_r && !s2_v_r)) begin
            res_r   <= {1'b0, !hit_r};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
